>>> hw/rtl/atd_pkg.sv
// shared widths, register indexes and reset values for the adaptive threshold detector
`timescale 1ns / 1ps
`default_nettype none
package atd_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int LIMIT_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int M_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_CALIB     = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 8'd10;
  localparam logic [CFG_W-1:0] CALIB_RST     = 8'd20;

  // result beat, highest bits first
  typedef struct packed {
    logic [M_DATA_W-LIMIT_W-3:0] pad;
    logic [LIMIT_W-1:0]          current_limit;
    logic                        active_now;
    logic                        event_res;
  } out_data_t;

endpackage
`default_nettype wire

>>> hw/rtl/adaptive_threshold_detector.sv
// adaptive threshold detector: calibration window, running mean limit, event detection
//
//  channel | dir | handshake              | payload
//  s       | in  | s_tvalid / s_tready    | s_tdata: sample
//  m       | out | m_tvalid / m_tready    | m_tdata: event_res, active_now, current_limit;
//          |     |                        | m_tuser: calibrating
//  cfg     | in  | cfg_we                 | cfg_index, cfg_data
//
// one beat per cycle while m is not stalled; a result appears in the cycle after its sample is taken
// the critical path is the running sum update, the reciprocal multiply for the mean
// and the threshold subtract
// the output register is refilled in the cycle it is drained, so a stall on m only
// holds s_tready low while a result waits; rst is synchronous and clears all state but the result register
`timescale 1ns / 1ps
`default_nettype none
module adaptive_threshold_detector #(
  parameter int WINDOW = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [atd_pkg::SAMPLE_W-1:0]    s_tdata,   // [7:0] sample
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [atd_pkg::M_DATA_W-1:0]         m_tdata,   // [0] event_res, [1] active_now,
                                                          // [9:2] current_limit, rest zero
  output logic                                 m_tuser,   // [0] calibrating
  input  wire logic                            cfg_we,
  input  wire logic [atd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [atd_pkg::CFG_W-1:0]       cfg_data
);
  import atd_pkg::*;

  localparam int IDX_W   = $clog2(WINDOW);
  localparam int SUM_W   = SAMPLE_W + IDX_W;
  localparam int SHIFT   = SUM_W + IDX_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** SHIFT) + WINDOW - 1) / WINDOW);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW - 1);

  logic [CFG_W-1:0]    threshold;
  logic [CFG_W-1:0]    calib_samples;
  logic [SAMPLE_W-1:0] window [WINDOW];
  logic [IDX_W-1:0]    window_index;
  logic [SUM_W-1:0]    sum;
  logic [LIMIT_W-1:0]  limit_reg;
  logic                active_flag;
  logic [CFG_W-1:0]    calib_count;
  out_data_t           out_data;
  logic                out_calib;

  logic                accept;
  logic                in_calib;
  logic                below;
  logic                push;
  logic                set_limit;
  logic [IDX_W-1:0]    window_index_next;
  logic [SUM_W-1:0]    sum_next;
  logic [PROD_W-1:0]   prod;
  logic [LIMIT_W-1:0]  limit_new;
  logic [LIMIT_W-1:0]  limit_next;
  logic                active_next;
  logic                event_next;
  logic [CFG_W-1:0]    calib_count_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    in_calib          = calib_count < calib_samples;
    below             = s_tdata < limit_reg;
    push              = in_calib || !below;
    calib_count_next  = calib_count + 8'd1;
    window_index_next = (window_index == LAST_IDX) ? '0 : window_index + IDX_W'(1);
    sum_next          = sum - SUM_W'(window[window_index]) + SUM_W'(s_tdata);
    prod              = PROD_W'(sum_next) * PROD_W'(RECIP);
    limit_new         = prod[SHIFT +: LIMIT_W] - threshold;
    set_limit         = in_calib ? (calib_count_next == calib_samples) : !below;
    limit_next        = set_limit ? limit_new : limit_reg;
    event_next        = !in_calib && below && !active_flag;
    if (in_calib) begin
      active_next = active_flag;
    end else begin
      active_next = below;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      calib_samples <= CALIB_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold     <= cfg_data;
        REG_CALIB:     calib_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        window[i] <= '0;
      end
      window_index <= '0;
      sum          <= '0;
      limit_reg    <= '0;
      active_flag  <= 1'b0;
      calib_count  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        if (push) begin
          window[window_index] <= s_tdata;
          window_index         <= window_index_next;
          sum                  <= sum_next;
        end
        if (in_calib) begin
          calib_count <= calib_count_next;
        end
        limit_reg   <= limit_next;
        active_flag <= active_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result register, loaded on every accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.pad           <= '0;
      out_data.current_limit <= limit_next;
      out_data.active_now    <= active_next;
      out_data.event_res     <= event_next;
      out_calib              <= in_calib;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_calib;

endmodule
`default_nettype wire

>>> hw/rtl/atd_checker.sv
// port-level checks for the adaptive threshold detector, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module atd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [atd_pkg::M_DATA_W-1:0]  m_tdata,
  input wire logic                          m_tuser
);
  import atd_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // an event always leaves the detector active
  a_event_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("event without active flag");

  // calibration beats never carry an event
  a_calib_no_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("event during calibration");

  // an empty output stage always takes a sample
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output stage");

  // a sample taken shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted sample gave no result");

endmodule

bind adaptive_threshold_detector atd_checker u_atd_checker (.*);
`default_nettype wire

>>> tb/adaptive_threshold_detector_check.sv
// result checker for the adaptive threshold detector: tracks state, compares result beats
`timescale 1ns / 1ps
module adaptive_threshold_detector_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [atd_pkg::SAMPLE_W-1:0]   s_tdata,   // [7:0] sample
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [atd_pkg::M_DATA_W-1:0]   m_tdata,   // [0] event_res, [1] active_now,
                                                    // [9:2] current_limit
  input  logic                           m_tuser,   // [0] calibrating
  input  logic                           cfg_we,
  input  logic [atd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atd_pkg::CFG_W-1:0]      cfg_data,
  output int                             fail_count,
  output int                             outstanding,
  output int                             event_count
);
  import atd_pkg::*;

  localparam int WIN_DEPTH = 4;

  typedef struct packed {
    logic               event_res;
    logic               active_now;
    logic [LIMIT_W-1:0] current_limit;
    logic               calibrating;
  } det_result_t;

  logic [CFG_W-1:0]    thr;
  logic [CFG_W-1:0]    calib_len;
  logic [SAMPLE_W-1:0] win [WIN_DEPTH];
  logic [1:0]          win_pos;
  logic [LIMIT_W-1:0]  limit_now;
  logic                armed;
  logic [7:0]          calib_seen;

  det_result_t results_due [$];
  det_result_t want;
  out_data_t   got;
  int          err_total = 0;
  int          events_total = 0;

  function automatic logic [LIMIT_W-1:0] mean_minus_threshold();
    logic [SAMPLE_W+1:0] total;
    total = win[0] + win[1] + win[2] + win[3];
    return total[SAMPLE_W+1:2] - thr;
  endfunction

  function automatic det_result_t step_detector(input logic [SAMPLE_W-1:0] smp);
    det_result_t r;
    r = '0;
    if (calib_seen < calib_len) begin
      r.calibrating = 1'b1;
      win[win_pos] = smp;
      win_pos = win_pos + 2'd1;
      calib_seen = calib_seen + 8'd1;
      if (calib_seen == calib_len) limit_now = mean_minus_threshold();
    end else if (smp < limit_now) begin
      if (!armed) begin
        armed = 1'b1;
        r.event_res = 1'b1;
      end
    end else begin
      win[win_pos] = smp;
      win_pos = win_pos + 2'd1;
      limit_now = mean_minus_threshold();
      armed = 1'b0;
    end
    r.active_now = armed;
    r.current_limit = limit_now;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [15:0] exp_v,
                            input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr = THRESHOLD_RST;
      calib_len = CALIB_RST;
      for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
      win_pos = '0;
      limit_now = '0;
      armed = 1'b0;
      calib_seen = '0;
      results_due.delete();
    end else begin
      if (s_tvalid && s_tready) results_due.push_back(step_detector(s_tdata));
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no sample pending: tdata %h tuser %b", m_tdata, m_tuser);
          err_total++;
        end else begin
          want = results_due.pop_front();
          got = m_tdata;
          flag_field("event_res", want.event_res, got.event_res);
          flag_field("active_now", want.active_now, got.active_now);
          flag_field("current_limit", want.current_limit, got.current_limit);
          flag_field("calibrating", want.calibrating, m_tuser);
          flag_field("tdata padding", '0, got.pad);
          if (want.event_res) events_total++;
        end
      end
      // a write at this edge only affects samples taken after it
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) thr = cfg_data;
        else if (cfg_index == REG_CALIB) calib_len = cfg_data;
      end
    end
    outstanding <= results_due.size();
    fail_count  <= err_total;
    event_count <= events_total;
  end

endmodule

>>> tb/adaptive_threshold_detector_test.sv
// top of the adaptive threshold detector test: clock, reset, stimulus, register settings and verdict
`timescale 1ns / 1ps
module adaptive_threshold_detector_test;
  import atd_pkg::*;

  localparam int ITEMS       = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED  = 25;

  // calibration fill, a window of 0,0,0,8 (limit wraps), then event, hold, clear, equality
  localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
    8'd255, 8'd0, 8'h55, 8'hAA, 8'd255, 8'd0, 8'd1, 8'd128, 8'd127, 8'd254,
    8'h0F, 8'hF0, 8'd64, 8'd32, 8'd16, 8'd2, 8'd0, 8'd0, 8'd0, 8'd8,
    8'd100, 8'd50, 8'd255, 8'd54, 8'd55
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [SAMPLE_W-1:0]  s_tdata;   // [7:0] sample
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;   // [0] event_res, [1] active_now, [9:2] current_limit
  logic                 m_tuser;   // [0] calibrating
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int outstanding;
  int event_count;

  int cycles = 0;
  int sent = 0;
  int burst_left = 0;
  int no_idle = 0;
  int phases = 0;
  int ready_mode = 0;
  int ready_left = 0;

  always #6 clk = ~clk;

  adaptive_threshold_detector uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  adaptive_threshold_detector_check result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .event_count (event_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("adaptive_threshold_detector_test NOT OK");
      $finish;
    end
  end

  // receiver stall pattern, switching at random among four ready modes
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 96);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 5) == 0);
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_sample(input logic [7:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] thr_v, input logic [7:0] calib_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr_v;
    @(posedge clk);
    cfg_index <= REG_CALIB;
    cfg_data  <= calib_v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a steady level near the baseline with dips below the limit, some noise
  function automatic logic [7:0] pick_sample(input int base, input int thr_v);
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = int'($urandom_range(0, 255));
      2, 3: v = base - thr_v - int'($urandom_range(1, 20));
      default: v = base + int'($urandom_range(0, 8));
    endcase
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return v[7:0];
  endfunction

  initial begin
    int thr_sel;
    int calib_sel;
    int base;
    int n;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    no_idle = 0;
    for (int i = 0; i < N_DIRECTED; i++) send_sample(DIRECTED[i]);
    drain();

    while (sent < ITEMS + N_DIRECTED) begin
      case (phases)
        0: begin
          thr_sel = 0;
          calib_sel = 0;
        end
        1: begin
          thr_sel = 255;
          calib_sel = 255;
        end
        2: begin
          // cuts the long calibration short with no limit update
          thr_sel = 20;
          calib_sel = 1;
        end
        default: begin
          case ($urandom_range(0, 19))
            0, 1: thr_sel = 0;
            2: thr_sel = 255;
            3, 4, 5: thr_sel = $urandom_range(0, 255);
            default: thr_sel = $urandom_range(0, 40);
          endcase
          case ($urandom_range(0, 19))
            0, 1, 2: calib_sel = 255;
            3, 4: calib_sel = 0;
            5: calib_sel = 1;
            6, 7, 8, 9, 10, 11: calib_sel = $urandom_range(0, 255);
            default: calib_sel = $urandom_range(0, 40);
          endcase
        end
      endcase
      write_regs(thr_sel[7:0], calib_sel[7:0]);
      base = $urandom_range(30, 230);
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) send_sample(pick_sample(base, thr_sel));
      drain();
      phases++;
    end

    repeat (8) @(posedge clk);
    $display("covered %0d samples over %0d register settings with %0d detection events,",
             sent, phases + 1, event_count);
    $display("under sender bursts, receiver stalls and stretches without idling");
    if (fail_count == 0) begin
      $display("adaptive_threshold_detector_test OK");
    end else begin
      $display("adaptive_threshold_detector_test NOT OK");
    end
    $finish;
  end

endmodule
